>>> rtl/core/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("console writer assertion failed");

// overlapping implication form
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

// next-cycle implication form
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons))

`endif

>>> rtl/core/tmcw_pkg.sv
`default_nettype none
package tmcw_pkg;
	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;

	localparam int ROW_W = 5;
	localparam int COL_W = 7;
	localparam int CELL_W = 11;
	localparam int PTR_W = $clog2(CELL_COUNT + 1);
	localparam int WORD_W = 16;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;

	localparam logic [CELL_W-1:0] LAST_ROW_POS = CELL_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);

	typedef struct packed {
		logic en;
		logic newline;
	} cursor_step_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CELL_W-1:0] pos;
	} cursor_t;
endpackage
`default_nettype wire

>>> rtl/core/tmcw_screen_ram.sv
`default_nettype none
module tmcw_screen_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [tmcw_pkg::CELL_W-1:0] waddr,
	input  wire logic [tmcw_pkg::WORD_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [tmcw_pkg::CELL_W-1:0] raddr,
	output logic      [tmcw_pkg::WORD_W-1:0] rdata
);
	logic [tmcw_pkg::WORD_W-1:0] mem_q [tmcw_pkg::CELL_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/tmcw_cursor.sv
`default_nettype none
module tmcw_cursor (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tmcw_pkg::cursor_step_t step,
	output tmcw_pkg::cursor_t           cursor,
	output logic                        scroll
);
	logic [tmcw_pkg::ROW_W-1:0]  row_q;
	logic [tmcw_pkg::COL_W-1:0]  col_q;
	logic [tmcw_pkg::CELL_W-1:0] pos_q;
	logic                        col_wrap;
	logic                        row_next;
	logic                        at_last;

	assign col_wrap = (col_q == tmcw_pkg::COL_W'(tmcw_pkg::SCREEN_COLUMNS - 1));
	assign row_next = step.newline || col_wrap;
	assign at_last = (row_q == tmcw_pkg::ROW_W'(tmcw_pkg::SCREEN_ROWS - 1));
	assign scroll = step.en && row_next && at_last;

	assign cursor.row = row_q;
	assign cursor.col = col_q;
	assign cursor.pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			pos_q <= '0;
		end else if (step.en) begin
			if (row_next) begin
				col_q <= '0;
				if (at_last) begin
					pos_q <= tmcw_pkg::LAST_ROW_POS;
				end else begin
					row_q <= row_q + 1'b1;
					if (step.newline) begin
						pos_q <= pos_q - tmcw_pkg::CELL_W'(col_q)
							+ tmcw_pkg::CELL_W'(tmcw_pkg::SCREEN_COLUMNS);
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				pos_q <= pos_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/text_mode_console_writer.sv
// 80x25 text console writer.
// Input channel (in_valid/in_stall): one beat is one action. action 0 puts
// char_code at the cursor with the current attribute (byte 10 is a newline
// and writes nothing); action 1 reads the cell at read_index.
// Output channel (out_valid/out_stall): exactly one beat per input beat,
// in order: the cell written or read, its 16-bit word and the cursor after.
// cfg_wr_en/cfg_wr_data load the attribute byte used for written cells and
// for the blank row left by a scroll; write it only while the block is idle.
// A put or a read is registered through ST_RESULT into the output register;
// the block takes one beat at a time, with in_stall high until it is idle again.
// A put that runs the cursor past the bottom row scrolls the screen through
// the sweep pointer: one cell copy a cycle over the upper rows, then one
// blank a cycle over the bottom row.
// Reset: cursor goes to row 0, column 0, attribute to 0x07, and the screen is
// cleared to 0x0720 by a pass over every cell during which in_stall is high.
// A stalled result holds in the output register; one more beat may be taken,
// and in_stall then stays high until the held result has been taken.
`default_nettype none
module text_mode_console_writer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  char_code,
	input  wire logic [10:0] read_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [10:0]      cell_number,
	output logic [15:0]      cell_word,
	output logic [4:0]       cursor_line,
	output logic [6:0]       cursor_column,
	output logic             did_scroll,
	output logic             wrote_cell
);
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_FILL,
		ST_RESULT
	} state_t;

	state_t                         state_q;
	logic [7:0]                     attr_q;
	logic [tmcw_pkg::PTR_W-1:0]     ptr_q;
	logic                           cp_valid_s1;
	logic [tmcw_pkg::CELL_W-1:0]    wr_ptr_s1;
	logic [tmcw_pkg::CELL_W-1:0]    res_number_q;
	logic [tmcw_pkg::WORD_W-1:0]    res_word_q;
	logic                           res_scroll_q;
	logic                           res_wrote_q;
	logic                           res_read_q;
	logic                           res_in_range_q;
	logic                           out_valid_q;
	logic [tmcw_pkg::CELL_W-1:0]    out_number_q;
	logic [tmcw_pkg::WORD_W-1:0]    out_word_q;
	logic [tmcw_pkg::ROW_W-1:0]     out_line_q;
	logic [tmcw_pkg::COL_W-1:0]     out_column_q;
	logic                           out_scroll_q;
	logic                           out_wrote_q;

	logic                           accept;
	logic                           is_newline;
	logic                           in_range;
	logic                           out_free;
	logic                           copy_more;
	tmcw_pkg::cursor_step_t         step;
	tmcw_pkg::cursor_t              cursor;
	logic                           scroll;
	logic                           ram_we;
	logic [tmcw_pkg::CELL_W-1:0]    ram_waddr;
	logic [tmcw_pkg::WORD_W-1:0]    ram_wdata;
	logic                           ram_re;
	logic [tmcw_pkg::CELL_W-1:0]    ram_raddr;
	logic [tmcw_pkg::WORD_W-1:0]    ram_rdata;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign is_newline = (char_code == tmcw_pkg::NEWLINE_CODE);
	assign in_range = (read_index < tmcw_pkg::CELL_W'(tmcw_pkg::CELL_COUNT));
	assign out_free = !out_valid_q || !out_stall;
	assign copy_more = (ptr_q != tmcw_pkg::PTR_W'(tmcw_pkg::CELL_COUNT));

	assign step.en = accept && !action;
	assign step.newline = is_newline;

	tmcw_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cursor (cursor),
		.scroll (scroll)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = ptr_q[tmcw_pkg::CELL_W-1:0];
		ram_wdata = {tmcw_pkg::RESET_ATTR, tmcw_pkg::BLANK_CODE};
		ram_re = 1'b0;
		ram_raddr = ptr_q[tmcw_pkg::CELL_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				ram_we = accept && !action && !is_newline;
				ram_waddr = cursor.pos;
				ram_wdata = {attr_q, char_code};
				ram_re = accept && action && in_range;
				ram_raddr = read_index;
			end
			ST_COPY: begin
				ram_we = cp_valid_s1;
				ram_waddr = wr_ptr_s1;
				ram_wdata = ram_rdata;
				ram_re = copy_more;
			end
			ST_FILL: begin
				ram_we = 1'b1;
				ram_wdata = {attr_q, tmcw_pkg::BLANK_CODE};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tmcw_screen_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tmcw_pkg::RESET_ATTR;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q <= '0;
			cp_valid_s1 <= 1'b0;
			wr_ptr_s1 <= '0;
			res_number_q <= '0;
			res_word_q <= '0;
			res_scroll_q <= 1'b0;
			res_wrote_q <= 1'b0;
			res_read_q <= 1'b0;
			res_in_range_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_number_q <= '0;
			out_word_q <= '0;
			out_line_q <= '0;
			out_column_q <= '0;
			out_scroll_q <= 1'b0;
			out_wrote_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (ptr_q == tmcw_pkg::PTR_W'(tmcw_pkg::CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_read_q <= action;
						res_in_range_q <= in_range;
						res_scroll_q <= !action && scroll;
						res_wrote_q <= !action && !is_newline;
						if (action) begin
							res_number_q <= read_index;
							res_word_q <= '0;
						end else if (is_newline) begin
							res_number_q <= '0;
							res_word_q <= '0;
						end else begin
							res_number_q <= cursor.pos;
							res_word_q <= {attr_q, char_code};
						end
						if (!action && scroll) begin
							ptr_q <= tmcw_pkg::PTR_W'(tmcw_pkg::SCREEN_COLUMNS);
							cp_valid_s1 <= 1'b0;
							state_q <= ST_COPY;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_COPY: begin
					if (copy_more) begin
						ptr_q <= ptr_q + 1'b1;
						wr_ptr_s1 <= ptr_q[tmcw_pkg::CELL_W-1:0]
							- tmcw_pkg::CELL_W'(tmcw_pkg::SCREEN_COLUMNS);
						cp_valid_s1 <= 1'b1;
					end else begin
						cp_valid_s1 <= 1'b0;
						if (!cp_valid_s1) begin
							ptr_q <= tmcw_pkg::PTR_W'(tmcw_pkg::CELL_COUNT
								- tmcw_pkg::SCREEN_COLUMNS);
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					if (ptr_q == tmcw_pkg::PTR_W'(tmcw_pkg::CELL_COUNT - 1)) begin
						state_q <= ST_RESULT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_number_q <= res_number_q;
						if (res_read_q) begin
							out_word_q <= res_in_range_q ? ram_rdata : '0;
						end else begin
							out_word_q <= res_word_q;
						end
						out_line_q <= cursor.row;
						out_column_q <= cursor.col;
						out_scroll_q <= res_scroll_q;
						out_wrote_q <= res_wrote_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign cell_number = out_number_q;
	assign cell_word = out_word_q;
	assign cursor_line = out_line_q;
	assign cursor_column = out_column_q;
	assign did_scroll = out_scroll_q;
	assign wrote_cell = out_wrote_q;
endmodule
`default_nettype wire

>>> rtl/core/tmcw_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tmcw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [10:0] cell_number,
	input wire logic [15:0] cell_word,
	input wire logic [4:0]  cursor_line,
	input wire logic [6:0]  cursor_column,
	input wire logic        did_scroll,
	input wire logic        wrote_cell
);
	logic [40:0] out_beat;
	logic        cursor_on_screen;
	logic        cursor_at_bottom_start;

	assign out_beat = {cell_number, cell_word, cursor_line, cursor_column,
		did_scroll, wrote_cell};
	assign cursor_on_screen = (cursor_line < 5'(tmcw_pkg::SCREEN_ROWS))
		&& (cursor_column < 7'(tmcw_pkg::SCREEN_COLUMNS));
	assign cursor_at_bottom_start = (cursor_line == 5'(tmcw_pkg::SCREEN_ROWS - 1))
		&& (cursor_column == 7'd0);

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_beat))

	// cursor stays on the screen
	`ASSERT_IMPL(a_cursor_range, clk, arst_n, out_valid, cursor_on_screen)

	// a scroll leaves the cursor at the start of the bottom row
	`ASSERT_IMPL(a_scroll_cursor, clk, arst_n, out_valid && did_scroll, cursor_at_bottom_start)

	// a written cell lies on the screen
	`ASSERT_IMPL(a_wrote_range, clk, arst_n, out_valid && wrote_cell, cell_number < 11'(2000))

	// no item is taken while the block is still working on the one before
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)
endmodule

bind text_mode_console_writer tmcw_checker u_tmcw_checker (.*);
`default_nettype wire

>>> tb/tb_text_mode_console_writer.sv
`timescale 1ns / 100ps
module tb_text_mode_console_writer;
	import tmcw_pkg::*;

	typedef enum logic {
		ACT_PUT  = 1'b0,
		ACT_READ = 1'b1
	} console_act_e;

	typedef struct packed {
		logic [CELL_W-1:0] number;
		logic [WORD_W-1:0] word;
		logic [ROW_W-1:0]  line;
		logic [COL_W-1:0]  column;
		logic              scrolled;
		logic              wrote;
	} cell_report_t;

	localparam int SCROLL_BUDGET = 150;
	localparam int SCROLL_PAUSE = 2100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = 1'b0;
	logic [7:0]  char_code = '0;
	logic [10:0] read_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] cell_number;
	logic [15:0] cell_word;
	logic [4:0]  cursor_line;
	logic [6:0]  cursor_column;
	logic        did_scroll;
	logic        wrote_cell;

	logic [WORD_W-1:0] shadow_screen [CELL_COUNT];
	int                shadow_row;
	int                shadow_col;
	logic [7:0]        shadow_attr;
	int                scroll_total;

	cell_report_t pending_reports [$];
	cell_report_t seen_report;
	cell_report_t due_report;
	int           mismatches = 0;
	int           send_gap_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_cycles = 0;

	text_mode_console_writer uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("text_mode_console_writer: mismatch");
		$finish;
	end

	// receiver side: random stalls plus a counted long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall = 1'b1;
				hold_cycles--;
			end else begin
				out_stall = ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic log_mismatch(input string what, input cell_report_t e, input cell_report_t g);
		mismatches++;
		if (mismatches <= 10)
			$display("result error (%s): expected cell %0d word %h row %0d col %0d scroll %b wrote %b, got cell %0d word %h row %0d col %0d scroll %b wrote %b",
				what, e.number, e.word, e.line, e.column, e.scrolled, e.wrote,
				g.number, g.word, g.line, g.column, g.scrolled, g.wrote);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_report = {cell_number, cell_word, cursor_line, cursor_column, did_scroll, wrote_cell};
			if (pending_reports.size() == 0) begin
				log_mismatch("unexpected beat", '0, seen_report);
			end else begin
				due_report = pending_reports.pop_front();
				if (seen_report !== due_report)
					log_mismatch("field", due_report, seen_report);
			end
		end
	end

	task automatic console_advance(input console_act_e act, input logic [7:0] ch,
			input logic [10:0] idx, output cell_report_t r);
		int pos;
		logic next_row;
		r = '0;
		next_row = 1'b0;
		if (act == ACT_READ) begin
			r.number = idx;
			r.word = (idx < CELL_COUNT) ? shadow_screen[idx] : '0;
		end else begin
			if (ch == NEWLINE_CODE) begin
				shadow_col = 0;
				next_row = 1'b1;
			end else begin
				pos = shadow_row * SCREEN_COLUMNS + shadow_col;
				shadow_screen[pos] = {shadow_attr, ch};
				r.word = {shadow_attr, ch};
				r.number = pos[CELL_W-1:0];
				r.wrote = 1'b1;
				shadow_col++;
				if (shadow_col >= SCREEN_COLUMNS) begin
					shadow_col = 0;
					next_row = 1'b1;
				end
			end
			if (next_row) begin
				shadow_row++;
				if (shadow_row >= SCREEN_ROWS) begin
					shadow_row = SCREEN_ROWS - 1;
					for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
						shadow_screen[i] = shadow_screen[i + SCREEN_COLUMNS];
					for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
						shadow_screen[i] = {shadow_attr, BLANK_CODE};
					r.scrolled = 1'b1;
					scroll_total++;
				end
			end
		end
		r.line = shadow_row[ROW_W-1:0];
		r.column = shadow_col[COL_W-1:0];
	endtask

	task automatic send_beat(input console_act_e act, input logic [7:0] ch, input logic [10:0] idx);
		cell_report_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		char_code = ch;
		read_index = idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		console_advance(act, ch, idx, r);
		pending_reports.push_back(r);
	endtask

	// stop offering, wait for every result and for any scroll sweep to finish
	task automatic settle;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SCROLL_PAUSE) @(posedge clk);
	endtask

	task automatic set_attribute(input logic [7:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		shadow_attr = value;
	endtask

	task automatic test_cleared_screen;
		send_beat(ACT_READ, 8'h00, 11'd0);
		send_beat(ACT_READ, 8'hFF, 11'd1);
		send_beat(ACT_READ, 8'h00, 11'd79);
		send_beat(ACT_READ, 8'h00, 11'd80);
		send_beat(ACT_READ, 8'h00, 11'(CELL_COUNT - 1));
		// past the last cell
		send_beat(ACT_READ, 8'h00, 11'(CELL_COUNT));
		send_beat(ACT_READ, 8'hFF, 11'h7FF);
		settle();
	endtask

	task automatic test_put_and_attribute;
		set_attribute(8'h00);
		send_beat(ACT_PUT, 8'h00, 11'h7FF);
		send_beat(ACT_PUT, 8'hFF, 11'd0);
		settle();
		set_attribute(8'hFF);
		send_beat(ACT_PUT, 8'h0D, 11'd0);
		send_beat(ACT_PUT, 8'h09, 11'd0);
		send_beat(ACT_PUT, NEWLINE_CODE, 11'd0);
		send_beat(ACT_PUT, 8'h41, 11'd0);
		send_beat(ACT_READ, 8'h00, 11'd0);
		send_beat(ACT_READ, 8'h00, 11'd80);
		settle();
	endtask

	task automatic test_output_hold;
		hold_cycles = 300;
		for (int n = 0; n < 12; n++)
			send_beat(($urandom_range(1) != 0) ? ACT_READ : ACT_PUT,
				8'($urandom_range(255)), 11'($urandom_range(2047)));
		settle();
	endtask

	task automatic test_random_traffic(input int beats);
		int kind;
		console_act_e act;
		logic [7:0] ch;
		logic [10:0] idx;
		for (int n = 0; n < beats; n++) begin
			kind = $urandom_range(99);
			ch = 8'($urandom_range(255));
			act = (kind < 62) ? ACT_PUT : ACT_READ;
			if (kind < 5)
				ch = NEWLINE_CODE;
			if (act == ACT_PUT && scroll_total >= SCROLL_BUDGET
					&& shadow_row == SCREEN_ROWS - 1
					&& (ch == NEWLINE_CODE || shadow_col == SCREEN_COLUMNS - 1))
				act = ACT_READ;
			if ($urandom_range(3) == 0)
				idx = 11'($urandom_range(CELL_COUNT - 1, LAST_ROW_POS));
			else
				idx = 11'($urandom_range(2047));
			send_beat(act, ch, idx);
		end
		settle();
	endtask

	initial begin
		shadow_row = 0;
		shadow_col = 0;
		shadow_attr = RESET_ATTR;
		scroll_total = 0;
		for (int i = 0; i < CELL_COUNT; i++)
			shadow_screen[i] = {RESET_ATTR, BLANK_CODE};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// screen clear pass after reset
		settle();

		send_gap_pct = 21;
		recv_stall_pct = 50;
		test_cleared_screen();
		test_put_and_attribute();
		test_output_hold();

		set_attribute(8'($urandom_range(255)));
		test_random_traffic(600);

		send_gap_pct = 50;
		recv_stall_pct = 21;
		set_attribute(8'($urandom_range(255)));
		test_random_traffic(600);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_attribute(8'h1E);
		test_random_traffic(600);

		repeat (50) @(posedge clk);
		mismatches += pending_reports.size();
		if (mismatches == 0)
			$display("text_mode_console_writer: match");
		else
			$display("text_mode_console_writer: mismatch");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_screen_ram.sv
rtl/core/tmcw_cursor.sv
rtl/core/text_mode_console_writer.sv
rtl/core/tmcw_checker.sv
tb/tb_text_mode_console_writer.sv
